// ===== hw/rtl/pie_pkg.sv =====
// ----------------------------------------------------------------------------
// pie_pkg: shared types and constants for the postfix integer evaluator
// Symbol codes, error codes and the sequencer state type.
// ----------------------------------------------------------------------------
package pie_pkg;

	localparam int STACK_DEPTH_DEF = 32;
	localparam int WORD_BITS_DEF   = 32;

	localparam logic [7:0] SYM_PLUS  = 8'h2B;
	localparam logic [7:0] SYM_MINUS = 8'h2D;
	localparam logic [7:0] SYM_MUL   = 8'h2A;
	localparam logic [7:0] SYM_DIV   = 8'h2F;
	localparam logic [7:0] SYM_POW   = 8'h5E;
	localparam logic [7:0] SYM_ZERO  = 8'h30;
	localparam logic [7:0] SYM_NINE  = 8'h39;

	typedef enum logic [2:0] {
		ERR_OK        = 3'd0,
		ERR_UNDERFLOW = 3'd1,
		ERR_OVERFLOW  = 3'd2,
		ERR_DIV_ZERO  = 3'd3,
		ERR_VARIABLE  = 3'd4,
		ERR_UNKNOWN   = 3'd5
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_ITER,
		ST_FIX,
		ST_WB,
		ST_OUT
	} state_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

endpackage

// ===== hw/rtl/postfix_integer_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_integer_evaluator: stack machine for postfix integer expressions
// Operand stack in a synchronous RAM; iterative divider; one multiplier shared by * and ^.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (valid/ready) carries one ASCII symbol a beat plus a last
//  flag. Output channel (valid/ready) returns exactly one result beat per
//  input beat: the stack top, depth, error code and answer flag.
//  Digits push; + - * / ^ pop two operands and push the result.
//  / takes one quotient bit a cycle; for ^ the running product and the
//  squaring take turns on one multiplier over the significant exponent
//  bits; a digit, an error, + or - and ^ with a negative exponent skip
//  the iteration. One symbol is in flight at a time: in_ready returns
//  once the previous result beat has been taken, so no new symbol is
//  accepted before the last one is through. A stalled receiver holds the
//  block.
//  The stack RAM has one read port with a registered read; the two operands
//  are read in consecutive cycles.
//  Reset clears the stack pointer and the sequencer; RAM contents are not
//  cleared, entries above the pointer never reach a result.
//  A last symbol clears the stack after its result.
module postfix_integer_evaluator #(
	parameter int STACK_DEPTH = pie_pkg::STACK_DEPTH_DEF,
	parameter int WORD_BITS   = pie_pkg::WORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  symbol,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [31:0]          top_value,
	output logic [5:0]                  stack_depth,
	output logic [2:0]                  error_code,
	output logic                        answer_ready
);
	import pie_pkg::*;

	localparam int PW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(WORD_BITS + 1);
	localparam logic [PW-1:0] DEPTH_V = PW'(STACK_DEPTH);

	// stack RAM
	logic [WORD_BITS-1:0] mem [STACK_DEPTH];
	logic [WORD_BITS-1:0] rd_data;
	logic [AW-1:0]        rd_addr, wr_addr;
	logic                 wr_en;
	logic [WORD_BITS-1:0] wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

	state_t state_q, state_d;
	logic [PW-1:0] sp_q, sp_d;
	logic [7:0] sym_q;
	logic last_q;
	logic [WORD_BITS-1:0] rhs_q, acc_q, aux_q, res_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_init;
	logic neg_q, rd2_q;
	err_t err_q;
	logic [WORD_BITS-1:0] top_q;
	logic [PW-1:0] dep_q;
	logic rdy_q;

	// symbol decode
	logic is_dig, is_op;
	assign is_dig = sym_q >= SYM_ZERO && sym_q <= SYM_NINE;
	assign is_op  = sym_q == SYM_PLUS || sym_q == SYM_MINUS || sym_q == SYM_MUL
		|| sym_q == SYM_DIV || sym_q == SYM_POW;

	logic [WORD_BITS-1:0] ones;
	assign ones = '1;

	// divide step (restoring, unsigned magnitudes)
	logic [WORD_BITS:0] rem_sh, rem_sub;
	assign rem_sh  = {aux_q, acc_q[WORD_BITS-1]};
	assign rem_sub = rem_sh - {1'b0, rhs_q};

	// multiplier (one per cycle, result registered)
	logic [WORD_BITS-1:0] mul_a, mul_b, mul_p;
	assign mul_p = WORD_BITS'(mul_a * mul_b);

	// iteration count loaded in EXEC
	always_comb begin
		cnt_init = '0;
		if (err_q == ERR_OK && is_op) begin
			if (sym_q == SYM_MUL) cnt_init = CW'(1);
			else if (sym_q == SYM_DIV && rhs_q != '0) cnt_init = CW'(WORD_BITS);
			else if (sym_q == SYM_POW && !rhs_q[WORD_BITS-1]) cnt_init = CW'(WORD_BITS);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_READ;
			ST_READ: state_d = ST_EXEC;
			ST_EXEC: state_d = ST_ITER;
			ST_ITER: if (cnt_q == '0) state_d = ST_FIX;
			ST_FIX:  state_d = ST_WB;
			ST_WB:   state_d = ST_OUT;
			ST_OUT:  if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = state_q == ST_OUT;
	assign top_value = 32'(signed'(top_q));
	assign stack_depth = 6'(dep_q);
	assign error_code  = err_q;
	assign answer_ready = rdy_q;

	// read address: rhs at sp-1 in IDLE-accept, lhs at sp-2 in READ,
	// old top at sp-1 (before update) in FIX, seen in WB
	logic [PW-1:0] sp_m1, sp_m2;
	assign sp_m1 = sp_q - PW'(1);
	assign sp_m2 = sp_q - PW'(2);
	logic [PW-1:0] acc_sp;
	assign acc_sp = (state_q == ST_IDLE) ? sp_m1 : (state_q == ST_READ) ? sp_m2 : sp_m1;
	assign rd_addr = AW'(acc_sp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	logic ok_op;
	assign ok_op = sp_q >= PW'(2) && sp_q <= DEPTH_V;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sp_q <= '0;
		else         sp_q <= sp_d;
	end

	// write-back in FIX; the quotient takes its sign on the way in
	always_comb begin
		sp_d = sp_q;
		wr_en = 1'b0;
		wr_addr = AW'(sp_q);
		wr_data = res_q;
		if (state_q == ST_FIX && err_q == ERR_OK) begin
			if (is_dig) begin
				wr_en = 1'b1;
				wr_addr = AW'(sp_q);
				wr_data = WORD_BITS'(sym_q - SYM_ZERO);
				sp_d = sp_q + PW'(1);
			end else if (is_op) begin
				wr_en = 1'b1;
				wr_addr = AW'(sp_m2);
				if (sym_q == SYM_DIV) wr_data = neg_q ? -acc_q : acc_q;
				sp_d = sp_m1;
			end
		end
		if (state_q == ST_OUT && out_ready && last_q) sp_d = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= ERR_OK;
			rdy_q <= 1'b0;
			sym_q <= '0;
			last_q <= 1'b0;
			rhs_q <= '0;
			acc_q <= '0;
			aux_q <= '0;
			res_q <= '0;
			cnt_q <= '0;
			neg_q <= 1'b0;
			rd2_q <= 1'b0;
			dep_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					sym_q <= symbol;
					last_q <= last;
				end
				ST_READ: begin
					rhs_q <= rd_data;
					if (is_dig) err_q <= (sp_q >= DEPTH_V) ? ERR_OVERFLOW : ERR_OK;
					else if (is_op) err_q <= ok_op ? ERR_OK : ERR_UNDERFLOW;
					else if (is_letter(sym_q)) err_q <= ERR_VARIABLE;
					else err_q <= ERR_UNKNOWN;
				end
				ST_EXEC: begin
					cnt_q <= cnt_init;
					if (err_q == ERR_OK && is_op) begin
						unique case (sym_q)
							SYM_PLUS:  res_q <= rd_data + rhs_q;
							SYM_MINUS: res_q <= rd_data - rhs_q;
							SYM_MUL: begin
								acc_q <= rd_data;
								aux_q <= rhs_q;
							end
							SYM_DIV: begin
								if (rhs_q == '0) err_q <= ERR_DIV_ZERO;
								else begin
									neg_q <= rd_data[WORD_BITS-1] ^ rhs_q[WORD_BITS-1];
									acc_q <= rd_data[WORD_BITS-1] ? -rd_data : rd_data;
									rhs_q <= rhs_q[WORD_BITS-1] ? -rhs_q : rhs_q;
									aux_q <= '0;
								end
							end
							default: begin // power
								if (rhs_q[WORD_BITS-1]) begin
									if (rd_data == WORD_BITS'(1)) res_q <= WORD_BITS'(1);
									else if (rd_data == ones)
										res_q <= rhs_q[0] ? ones : WORD_BITS'(1);
									else res_q <= '0;
								end else begin
									res_q <= WORD_BITS'(1);
									acc_q <= rd_data;
								end
							end
						endcase
					end
				end
				ST_ITER: if (cnt_q != '0) begin
					if (sym_q == SYM_MUL) begin
						res_q <= mul_p;
						cnt_q <= cnt_q - CW'(1);
					end else if (sym_q == SYM_DIV) begin
						cnt_q <= cnt_q - CW'(1);
						if (!rem_sub[WORD_BITS]) begin
							aux_q <= rem_sub[WORD_BITS-1:0];
							acc_q <= {acc_q[WORD_BITS-2:0], 1'b1};
						end else begin
							aux_q <= rem_sh[WORD_BITS-1:0];
							acc_q <= {acc_q[WORD_BITS-2:0], 1'b0};
						end
					end else begin
						// power: alternate multiply-into-result, then square
						if (rhs_q == '0) begin
							cnt_q <= '0;
						end else if (rd2_q) begin
							acc_q <= mul_p;
							rhs_q <= rhs_q >> 1;
							rd2_q <= 1'b0;
							cnt_q <= cnt_q - CW'(1);
						end else begin
							if (rhs_q[0]) res_q <= mul_p;
							rd2_q <= 1'b1;
						end
					end
				end
				ST_FIX: ;
				ST_WB: ;
				ST_OUT: ;
				default: ;
			endcase
			if (state_q == ST_EXEC) rd2_q <= 1'b0;
			// final outputs: read after the write settles
			if (state_q == ST_WB) begin
				dep_q <= last_q ? '0 : sp_q;
				rdy_q <= last_q && sp_q != '0 && err_q == ERR_OK;
				if (last_q && sp_q == '0 && err_q == ERR_OK) err_q <= ERR_UNDERFLOW;
			end
		end
	end

	// the write lands at FIX; the RAM read issued in FIX still sees the old
	// entry, so the top seen in WB is taken from the written value
	logic [WORD_BITS-1:0] wb_top;
	// top data arrives in WB, after the write; forward written value
	logic wrote_q;
	logic [WORD_BITS-1:0] wdat_q;
	always_ff @(posedge clk) begin
		wrote_q <= wr_en;
		wdat_q  <= wr_data;
	end
	assign wb_top = wrote_q ? wdat_q : rd_data;
	always_ff @(posedge clk) begin
		if (state_q == ST_WB) top_q <= (sp_q == '0) ? '0 : wb_top;
	end

	// multiplier operand select
	always_comb begin
		if (sym_q == SYM_MUL) begin
			mul_a = acc_q;
			mul_b = aux_q;
		end else if (rd2_q) begin
			mul_a = acc_q;
			mul_b = acc_q;
		end else begin
			mul_a = res_q;
			mul_b = acc_q;
		end
	end

endmodule

// ===== hw/rtl/pie_checker.sv =====
// ----------------------------------------------------------------------------
// pie_checker: port-level checks for the postfix integer evaluator
// Handshake and result sanity over time.
// ----------------------------------------------------------------------------
module pie_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [5:0]  stack_depth,
	input logic [2:0]  error_code,
	input logic        answer_ready
);
	import pie_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(stack_depth))
		else $error("result beat dropped while stalled");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result waits");

	a_ans_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && answer_ready |-> error_code == ERR_OK && stack_depth == 6'd0)
		else $error("answer with error or nonzero depth");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_code <= ERR_UNKNOWN)
		else $error("bad error code");

endmodule

bind postfix_integer_evaluator pie_checker u_pie_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .stack_depth(stack_depth),
	.error_code(error_code), .answer_ready(answer_ready)
);
